// ===== rtl/core/ptmf_pkg.sv =====
// ----------------------------------------------------------------------------
// ptmf_pkg
// shared widths, codes and controller/datapath command types for the
// pan/tilt motion follower
// ----------------------------------------------------------------------------
package ptmf_pkg;

    // field widths fixed by the item and result formats
    localparam int COORD_W    = 8;
    localparam int TIME_W     = 32;
    localparam int PAN_OUT_W  = 5;
    localparam int TILT_OUT_W = 4;

    // configuration register widths
    localparam int DZ_W = 5;
    localparam int MS_W = 4;
    localparam int TO_W = 8;

    // configuration reset values
    localparam logic [DZ_W-1:0] DEAD_ZONE_RST = 5'd2;
    localparam logic [MS_W-1:0] MAX_STEP_RST  = 4'd3;
    localparam logic [MS_W-1:0] MAX_STEP_TOP  = 4'd10;
    localparam logic [TO_W-1:0] TIMEOUT_RST   = 8'd10;

    // apb
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 4;

    typedef enum logic [1:0] {
        REG_DEAD_ZONE   = 2'd0,
        REG_MAX_STEP    = 2'd1,
        REG_HOME_ENABLE = 2'd2,
        REG_HOME_TMO    = 2'd3
    } ptmf_reg_t;

    // item opcodes
    localparam logic OP_REPORT = 1'b0;
    localparam logic OP_POLL   = 1'b1;

    // commands from the controller to the datapath
    typedef struct packed {
        logic load;
        logic div_step;
        logic limit;
        logic commit;
    } ptmf_cmd_t;

    // status from the datapath to the controller
    typedef struct packed {
        logic is_poll;
    } ptmf_stat_t;

endpackage

// ===== rtl/core/ptmf_item_if.sv =====
// ----------------------------------------------------------------------------
// ptmf_item_if
// input channel: motion reports and no-motion polls
// ----------------------------------------------------------------------------
interface ptmf_item_if;
    logic                              valid;
    logic                              ready;
    logic                              op;
    logic [ptmf_pkg::COORD_W-1:0]      motion_column;
    logic [ptmf_pkg::COORD_W-1:0]      motion_row;
    logic [ptmf_pkg::COORD_W-1:0]      grid_width;
    logic [ptmf_pkg::COORD_W-1:0]      grid_height;
    logic [ptmf_pkg::TIME_W-1:0]       now_seconds;

    modport source (
        output valid, op, motion_column, motion_row, grid_width, grid_height,
               now_seconds,
        input  ready
    );

    modport sink (
        input  valid, op, motion_column, motion_row, grid_width, grid_height,
               now_seconds,
        output ready
    );
endinterface

// ===== rtl/core/ptmf_result_if.sv =====
// ----------------------------------------------------------------------------
// ptmf_result_if
// output channel: motor move commands and position status
// ----------------------------------------------------------------------------
interface ptmf_result_if;
    logic                              valid;
    logic                              ready;
    logic                              move_valid;
    logic                              pan_direction;
    logic [ptmf_pkg::PAN_OUT_W-1:0]    pan_distance;
    logic                              tilt_direction;
    logic [ptmf_pkg::TILT_OUT_W-1:0]   tilt_distance;
    logic [ptmf_pkg::PAN_OUT_W-1:0]    pan_now;
    logic [ptmf_pkg::TILT_OUT_W-1:0]   tilt_now;
    logic                              active_flag;
    logic                              tracking_started;
    logic                              went_home;

    modport source (
        output valid, move_valid, pan_direction, pan_distance, tilt_direction,
               tilt_distance, pan_now, tilt_now, active_flag, tracking_started,
               went_home,
        input  ready
    );

    modport sink (
        input  valid, move_valid, pan_direction, pan_distance, tilt_direction,
               tilt_distance, pan_now, tilt_now, active_flag, tracking_started,
               went_home,
        output ready
    );
endinterface

// ===== rtl/core/ptmf_ctrl.sv =====
// ----------------------------------------------------------------------------
// ptmf_ctrl
// sequencer: accept, divide, limit, apply; owns the result valid flag
// ----------------------------------------------------------------------------
module ptmf_ctrl #(
    parameter int DIV_STEPS = 13
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    output logic                  out_valid,
    input  logic                  out_ready,
    input  ptmf_pkg::ptmf_stat_t  stat,
    output ptmf_pkg::ptmf_cmd_t   cmd
);

    localparam int CW = $clog2(DIV_STEPS);

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_DIV   = 4'b0010,
        ST_LIMIT = 4'b0100,
        ST_APPLY = 4'b1000
    } state_t;

    state_t          state_reg, state_next;
    logic [CW-1:0]   cnt_reg, cnt_next;
    logic            out_valid_reg, out_valid_next;

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd            = '0;
        in_ready       = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    cnt_next   = CW'(DIV_STEPS - 1);
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (stat.is_poll)
                begin
                    state_next = ST_LIMIT;
                end
                else
                begin
                    cmd.div_step = 1'b1;
                    if (cnt_reg == '0)
                        state_next = ST_LIMIT;
                    else
                        cnt_next = cnt_reg - 1'b1;
                end
            end
            ST_LIMIT:
            begin
                cmd.limit  = 1'b1;
                state_next = ST_APPLY;
            end
            ST_APPLY:
            begin
                // hold until the result register is free
                if (!out_valid_reg || out_ready)
                begin
                    cmd.commit     = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

// ===== rtl/core/ptmf_dp.sv =====
// ----------------------------------------------------------------------------
// ptmf_dp
// datapath: centroid scaling dividers, dead zone and step limit, travel
// bounds, head position and timeout state, result register
// ----------------------------------------------------------------------------
module ptmf_dp #(
    parameter int PAN_MAX  = 31,
    parameter int TILT_MAX = 15
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  ptmf_pkg::ptmf_cmd_t                 cmd,
    output ptmf_pkg::ptmf_stat_t                stat,
    // item payload, sampled on load
    input  logic                                op,
    input  logic [ptmf_pkg::COORD_W-1:0]        motion_column,
    input  logic [ptmf_pkg::COORD_W-1:0]        motion_row,
    input  logic [ptmf_pkg::COORD_W-1:0]        grid_width,
    input  logic [ptmf_pkg::COORD_W-1:0]        grid_height,
    input  logic [ptmf_pkg::TIME_W-1:0]         now_seconds,
    // configuration
    input  logic [ptmf_pkg::DZ_W-1:0]           dead_zone,
    input  logic [ptmf_pkg::MS_W-1:0]           step_limit,
    input  logic                                home_enable,
    input  logic [ptmf_pkg::TO_W-1:0]           home_timeout,
    // result payload
    output logic                                move_valid,
    output logic                                pan_direction,
    output logic [ptmf_pkg::PAN_OUT_W-1:0]      pan_distance,
    output logic                                tilt_direction,
    output logic [ptmf_pkg::TILT_OUT_W-1:0]     tilt_distance,
    output logic [ptmf_pkg::PAN_OUT_W-1:0]      pan_now,
    output logic [ptmf_pkg::TILT_OUT_W-1:0]     tilt_now,
    output logic                                active_flag,
    output logic                                tracking_started,
    output logic                                went_home
);

    localparam int CW     = ptmf_pkg::COORD_W;
    localparam int PW     = $clog2(PAN_MAX + 1);
    localparam int TW     = $clog2(TILT_MAX + 1);
    localparam int MW     = (PW > TW) ? PW : TW;
    localparam int DW     = CW + MW;
    localparam int EW     = DW + 2;
    localparam int PAN_C  = PAN_MAX / 2;
    localparam int TILT_C = TILT_MAX / 2;

    typedef logic signed [EW-1:0] err_t;

    // item registers
    logic                           op_reg;
    logic [ptmf_pkg::TIME_W-1:0]    now_reg;
    logic                           pan_wide_reg, tilt_wide_reg;
    logic [CW-1:0]                  pan_den_reg, tilt_den_reg;
    logic [CW-1:0]                  pan_rem_reg, tilt_rem_reg;
    logic [DW-1:0]                  pan_q_reg, tilt_q_reg;
    err_t                           dx_reg, dy_reg;
    logic                           home_reg;

    // persistent head state
    logic [PW-1:0]                  pan_pos_reg;
    logic [TW-1:0]                  tilt_pos_reg;
    logic [ptmf_pkg::TIME_W-1:0]    last_reg;
    logic                           seen_reg;
    logic                           active_reg;

    // result registers
    logic                               move_valid_reg;
    logic                               pan_dir_reg;
    logic [ptmf_pkg::PAN_OUT_W-1:0]     pan_dist_reg;
    logic                               tilt_dir_reg;
    logic [ptmf_pkg::TILT_OUT_W-1:0]    tilt_dist_reg;
    logic [ptmf_pkg::PAN_OUT_W-1:0]     pan_now_reg;
    logic [ptmf_pkg::TILT_OUT_W-1:0]    tilt_now_reg;
    logic                               active_out_reg;
    logic                               started_reg;
    logic                               went_home_reg;

    function automatic err_t limit_err(input err_t e, input err_t dz, input err_t lim);
        err_t mag;
        mag = (e < 0) ? -e : e;
        if (mag <= dz)
            return '0;
        else if (e > lim)
            return lim;
        else if (e < -lim)
            return -lim;
        else
            return e;
    endfunction

    function automatic err_t bound_err(input err_t pos, input err_t d, input err_t top);
        err_t s;
        s = pos + d;
        if (s < 0)
            return -pos;
        else if (s > top)
            return top - pos;
        else
            return d;
    endfunction

    // one restoring division step per lane
    logic [CW:0]    pan_trial, tilt_trial;
    logic           pan_ge, tilt_ge;

    always_comb
    begin
        pan_trial  = {pan_rem_reg, pan_q_reg[DW-1]};
        tilt_trial = {tilt_rem_reg, tilt_q_reg[DW-1]};
        pan_ge     = pan_trial >= {1'b0, pan_den_reg};
        tilt_ge    = tilt_trial >= {1'b0, tilt_den_reg};
    end

    // limit stage
    err_t                           pan_pos_e, tilt_pos_e;
    err_t                           pan_tgt, tilt_tgt;
    err_t                           dz_e, lim_e;
    logic [ptmf_pkg::TIME_W-1:0]    elapsed;
    logic                           home_due;

    always_comb
    begin
        pan_pos_e  = EW'(pan_pos_reg);
        tilt_pos_e = EW'(tilt_pos_reg);
        pan_tgt    = pan_wide_reg  ? err_t'({2'b00, pan_q_reg})  : err_t'(EW'(PAN_C));
        tilt_tgt   = tilt_wide_reg ? err_t'({2'b00, tilt_q_reg}) : err_t'(EW'(TILT_C));
        dz_e       = EW'(dead_zone);
        lim_e      = EW'(step_limit);
        elapsed    = now_reg - last_reg;
        home_due   = home_enable && seen_reg
                     && (elapsed >= ptmf_pkg::TIME_W'(home_timeout))
                     && ((pan_pos_reg != PW'(PAN_C)) || (tilt_pos_reg != TW'(TILT_C)));
    end

    // apply stage
    err_t   dx_b, dy_b, dx_mag, dy_mag, pan_new, tilt_new;
    logic   moved;

    always_comb
    begin
        dx_b     = bound_err(pan_pos_e, dx_reg, err_t'(EW'(PAN_MAX)));
        dy_b     = bound_err(tilt_pos_e, dy_reg, err_t'(EW'(TILT_MAX)));
        dx_mag   = (dx_b < 0) ? -dx_b : dx_b;
        dy_mag   = (dy_b < 0) ? -dy_b : dy_b;
        pan_new  = pan_pos_e + dx_b;
        tilt_new = tilt_pos_e + dy_b;
        moved    = (dx_b != 0) || (dy_b != 0);
    end

    // working registers, no reset needed
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg        <= op;
            now_reg       <= now_seconds;
            pan_wide_reg  <= grid_width > CW'(1);
            tilt_wide_reg <= grid_height > CW'(1);
            pan_den_reg   <= grid_width - 1'b1;
            tilt_den_reg  <= grid_height - 1'b1;
            pan_rem_reg   <= '0;
            tilt_rem_reg  <= '0;
            pan_q_reg     <= DW'({{MW{1'b0}}, motion_column} * DW'(PAN_MAX));
            tilt_q_reg    <= DW'({{MW{1'b0}}, motion_row} * DW'(TILT_MAX));
        end
        if (cmd.div_step)
        begin
            pan_rem_reg  <= pan_ge  ? CW'(pan_trial - {1'b0, pan_den_reg})
                                    : pan_trial[CW-1:0];
            tilt_rem_reg <= tilt_ge ? CW'(tilt_trial - {1'b0, tilt_den_reg})
                                    : tilt_trial[CW-1:0];
            pan_q_reg    <= {pan_q_reg[DW-2:0], pan_ge};
            tilt_q_reg   <= {tilt_q_reg[DW-2:0], tilt_ge};
        end
        if (cmd.limit)
        begin
            if (op_reg == ptmf_pkg::OP_POLL)
            begin
                dx_reg   <= home_due ? (err_t'(EW'(PAN_C)) - pan_pos_e) : '0;
                dy_reg   <= home_due ? (err_t'(EW'(TILT_C)) - tilt_pos_e) : '0;
                home_reg <= home_due;
            end
            else
            begin
                dx_reg   <= limit_err(pan_tgt - pan_pos_e, dz_e, lim_e);
                dy_reg   <= limit_err(tilt_tgt - tilt_pos_e, dz_e, lim_e);
                home_reg <= 1'b0;
            end
        end
        if (cmd.commit)
        begin
            move_valid_reg <= moved;
            pan_dir_reg    <= dx_b < 0;
            pan_dist_reg   <= dx_mag[ptmf_pkg::PAN_OUT_W-1:0];
            tilt_dir_reg   <= dy_b > 0;
            tilt_dist_reg  <= dy_mag[ptmf_pkg::TILT_OUT_W-1:0];
            pan_now_reg    <= pan_new[ptmf_pkg::PAN_OUT_W-1:0];
            tilt_now_reg   <= tilt_new[ptmf_pkg::TILT_OUT_W-1:0];
            active_out_reg <= op_reg == ptmf_pkg::OP_REPORT;
            started_reg    <= (op_reg == ptmf_pkg::OP_REPORT) && !active_reg;
            went_home_reg  <= home_reg && moved;
        end
    end

    // head state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pan_pos_reg  <= PW'(PAN_C);
            tilt_pos_reg <= TW'(TILT_C);
            last_reg     <= '0;
            seen_reg     <= 1'b0;
            active_reg   <= 1'b1;
        end
        else if (cmd.commit)
        begin
            pan_pos_reg  <= pan_new[PW-1:0];
            tilt_pos_reg <= tilt_new[TW-1:0];
            active_reg   <= op_reg == ptmf_pkg::OP_REPORT;
            if (op_reg == ptmf_pkg::OP_REPORT)
            begin
                last_reg <= now_reg;
                seen_reg <= 1'b1;
            end
            else if (home_reg && moved)
            begin
                seen_reg <= 1'b0;
            end
        end
    end

    assign stat.is_poll     = op_reg == ptmf_pkg::OP_POLL;
    assign move_valid       = move_valid_reg;
    assign pan_direction    = pan_dir_reg;
    assign pan_distance     = pan_dist_reg;
    assign tilt_direction   = tilt_dir_reg;
    assign tilt_distance    = tilt_dist_reg;
    assign pan_now          = pan_now_reg;
    assign tilt_now         = tilt_now_reg;
    assign active_flag      = active_out_reg;
    assign tracking_started = started_reg;
    assign went_home        = went_home_reg;

endmodule

// ===== rtl/core/pan_tilt_motion_follower_core.sv =====
// ----------------------------------------------------------------------------
// pan_tilt_motion_follower_core
// steers a pan/tilt head toward reported motion and back to centre on timeout
// ----------------------------------------------------------------------------
// one item in, one result out. a motion report maps the macroblock centroid to
// a pan/tilt target (centroid * travel / (grid - 1), centre for a grid one wide
// or less), ignores errors inside the dead zone, limits each axis to max_step
// and clamps to the travel bounds. a no-motion poll clears the active flag and,
// when enabled and home_timeout seconds have passed since the last report,
// drives the head back to centre. a report passes accept, the bit-serial
// divider that runs both axes side by side, one quotient bit a cycle, then
// limit and apply; a poll does no divide steps. a finished result sits in
// an output register, so the next item is taken while it waits.
// configuration is written over apb at byte address 4*i and should only
// change while the block is idle.
// ----------------------------------------------------------------------------
module pan_tilt_motion_follower_core #(
    parameter int PAN_MAX  = 31,
    parameter int TILT_MAX = 15
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // item and result channels
    ptmf_item_if.sink                           motion,
    ptmf_result_if.source                       command,
    // apb configuration port
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [ptmf_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [ptmf_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [ptmf_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                pready
);

    // divider length follows the wider of the two scaled numerators
    localparam int PW        = $clog2(PAN_MAX + 1);
    localparam int TW        = $clog2(TILT_MAX + 1);
    localparam int MW        = (PW > TW) ? PW : TW;
    localparam int DIV_STEPS = ptmf_pkg::COORD_W + MW;

    // ------------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------------
    logic [ptmf_pkg::DZ_W-1:0]  dead_zone_reg;
    logic [ptmf_pkg::MS_W-1:0]  max_step_reg;
    logic                       home_en_reg;
    logic [ptmf_pkg::TO_W-1:0]  home_tmo_reg;
    logic                       cfg_write;
    ptmf_pkg::ptmf_reg_t        cfg_sel;
    logic [ptmf_pkg::MS_W-1:0]  step_limit;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign cfg_sel   = ptmf_pkg::ptmf_reg_t'(paddr[3:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dead_zone_reg <= ptmf_pkg::DEAD_ZONE_RST;
            max_step_reg  <= ptmf_pkg::MAX_STEP_RST;
            home_en_reg   <= 1'b0;
            home_tmo_reg  <= ptmf_pkg::TIMEOUT_RST;
        end
        else if (cfg_write)
        begin
            case (cfg_sel)
                ptmf_pkg::REG_DEAD_ZONE:   dead_zone_reg <= pwdata[ptmf_pkg::DZ_W-1:0];
                ptmf_pkg::REG_MAX_STEP:    max_step_reg  <= pwdata[ptmf_pkg::MS_W-1:0];
                ptmf_pkg::REG_HOME_ENABLE: home_en_reg   <= pwdata[0];
                ptmf_pkg::REG_HOME_TMO:    home_tmo_reg  <= pwdata[ptmf_pkg::TO_W-1:0];
                default: ;
            endcase
        end
    end

    // register readback
    always_comb
    begin
        prdata = '0;
        case (cfg_sel)
            ptmf_pkg::REG_DEAD_ZONE:   prdata = ptmf_pkg::APB_DATA_W'(dead_zone_reg);
            ptmf_pkg::REG_MAX_STEP:    prdata = ptmf_pkg::APB_DATA_W'(max_step_reg);
            ptmf_pkg::REG_HOME_ENABLE: prdata = ptmf_pkg::APB_DATA_W'(home_en_reg);
            ptmf_pkg::REG_HOME_TMO:    prdata = ptmf_pkg::APB_DATA_W'(home_tmo_reg);
            default:                   prdata = '0;
        endcase
    end

    // a step of zero or beyond the supported range falls back to the default
    assign step_limit = ((max_step_reg == '0) || (max_step_reg > ptmf_pkg::MAX_STEP_TOP))
                        ? ptmf_pkg::MAX_STEP_RST : max_step_reg;

    // ------------------------------------------------------------------------
    // controller and datapath
    // ------------------------------------------------------------------------
    ptmf_pkg::ptmf_cmd_t    cmd;
    ptmf_pkg::ptmf_stat_t   stat;

    ptmf_ctrl #(
        .DIV_STEPS (DIV_STEPS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (motion.valid),
        .in_ready  (motion.ready),
        .out_valid (command.valid),
        .out_ready (command.ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    ptmf_dp #(
        .PAN_MAX  (PAN_MAX),
        .TILT_MAX (TILT_MAX)
    ) u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .stat             (stat),
        .op               (motion.op),
        .motion_column    (motion.motion_column),
        .motion_row       (motion.motion_row),
        .grid_width       (motion.grid_width),
        .grid_height      (motion.grid_height),
        .now_seconds      (motion.now_seconds),
        .dead_zone        (dead_zone_reg),
        .step_limit       (step_limit),
        .home_enable      (home_en_reg),
        .home_timeout     (home_tmo_reg),
        .move_valid       (command.move_valid),
        .pan_direction    (command.pan_direction),
        .pan_distance     (command.pan_distance),
        .tilt_direction   (command.tilt_direction),
        .tilt_distance    (command.tilt_distance),
        .pan_now          (command.pan_now),
        .tilt_now         (command.tilt_now),
        .active_flag      (command.active_flag),
        .tracking_started (command.tracking_started),
        .went_home        (command.went_home)
    );

endmodule

// ===== verif/pan_tilt_motion_follower_core_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// pan_tilt_motion_follower_core_tb
// self-checking bench for the pan/tilt motion follower: a stimulus table of
// corner cases followed by shaped random reports and polls, each result
// compared field by field against a cycle-free model of the head position
// ----------------------------------------------------------------------------
module pan_tilt_motion_follower_core_tb;

    localparam int PAN_TOP     = 31;
    localparam int TILT_TOP    = 15;
    localparam int PAN_CENTRE  = PAN_TOP / 2;
    localparam int TILT_CENTRE = TILT_TOP / 2;
    localparam int RANDOM_SEGS = 6;
    localparam int SEG_BEATS   = 156;

    // one input beat
    typedef struct {
        logic                          op;
        logic [ptmf_pkg::COORD_W-1:0]  col;
        logic [ptmf_pkg::COORD_W-1:0]  row;
        logic [ptmf_pkg::COORD_W-1:0]  gw;
        logic [ptmf_pkg::COORD_W-1:0]  gh;
        logic [ptmf_pkg::TIME_W-1:0]   now_s;
    } motion_item_t;

    // one result beat, in port order
    typedef struct packed {
        logic                             move_valid;
        logic                             pan_direction;
        logic [ptmf_pkg::PAN_OUT_W-1:0]   pan_distance;
        logic                             tilt_direction;
        logic [ptmf_pkg::TILT_OUT_W-1:0]  tilt_distance;
        logic [ptmf_pkg::PAN_OUT_W-1:0]   pan_now;
        logic [ptmf_pkg::TILT_OUT_W-1:0]  tilt_now;
        logic                             active_flag;
        logic                             tracking_started;
        logic                             went_home;
    } move_cmd_t;

    // a row of the directed table: either a register write or a beat
    typedef struct {
        bit                    is_cfg;
        ptmf_pkg::ptmf_reg_t   cfg_reg;
        int unsigned           cfg_val;
        motion_item_t          item;
        bit                    typed;
        move_cmd_t             want;
    } stim_row_t;

    logic clk;
    logic rst_n;
    logic                            psel;
    logic                            penable;
    logic                            pwrite;
    logic [ptmf_pkg::APB_ADDR_W-1:0] paddr;
    logic [ptmf_pkg::APB_DATA_W-1:0] pwdata;
    logic [ptmf_pkg::APB_DATA_W-1:0] prdata;
    logic                            pready;

    ptmf_item_if   motion_bus ();
    ptmf_result_if command_bus ();

    pan_tilt_motion_follower_core u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .motion  (motion_bus),
        .command (command_bus),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // model copy of the head and its settings
    int             head_pan;
    int             head_tilt;
    logic [31:0]    last_report_s;
    bit             report_seen;
    bit             tracking_on;
    int             cfg_dead_zone;
    int             cfg_max_step;
    bit             cfg_home_en;
    int             cfg_home_tmo;

    move_cmd_t      pending_moves[$];
    stim_row_t      directed_rows[$];

    // idle percentages, changed per phase by the main sequence
    int             src_idle_pct;
    int             snk_idle_pct;
    logic [31:0]    clock_s;

    int mismatch_count;
    int n_reports;
    int n_polls;
    int n_checked;
    int n_moves;
    int n_homes;
    int n_starts;
    int n_cfg_writes;

    // ------------------------------------------------------------------------
    // clock and timeout
    // ------------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // well beyond the slowest legal run, which needs only a few hundred us
    initial
    begin
        #5_000_000;
        $display("Verification failed");
        $finish;
    end

    // ------------------------------------------------------------------------
    // mismatch reporting
    // ------------------------------------------------------------------------
    task automatic flag_mismatch(input string what, input longint got, input longint want);
        if (mismatch_count < 50)
            $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $time);
        mismatch_count++;
    endtask

    // ------------------------------------------------------------------------
    // head model
    // ------------------------------------------------------------------------
    // error inside the dead zone is dropped, otherwise clipped to the step limit
    function automatic int clip_step(input int err, input int dz, input int lim);
        int mag;
        mag = (err < 0) ? -err : err;
        if (mag <= dz)
            return 0;
        if (err > lim)
            return lim;
        if (err < -lim)
            return -lim;
        return err;
    endfunction

    // keep the move inside 0..top
    function automatic int bound_step(input int pos, input int d, input int top);
        int r;
        r = d;
        if (pos + r < 0)
            r = -pos;
        if (pos + r > top)
            r = top - pos;
        return r;
    endfunction

    function automatic move_cmd_t predict_move(input motion_item_t it);
        int          dpan;
        int          dtilt;
        int          tgt_pan;
        int          tgt_tilt;
        int          step_lim;
        logic [31:0] elapsed;
        bit          started;
        bit          home;
        move_cmd_t   res;
        dpan    = 0;
        dtilt   = 0;
        started = 1'b0;
        home    = 1'b0;
        if (it.op == ptmf_pkg::OP_POLL)
        begin
            tracking_on = 1'b0;
            // elapsed seconds wrap modulo 2^32
            elapsed = it.now_s - last_report_s;
            if (cfg_home_en && report_seen && elapsed >= 32'(cfg_home_tmo)
                && (head_pan != PAN_CENTRE || head_tilt != TILT_CENTRE))
            begin
                dpan        = PAN_CENTRE - head_pan;
                dtilt       = TILT_CENTRE - head_tilt;
                report_seen = 1'b0;
                home        = 1'b1;
            end
        end
        else
        begin
            last_report_s = it.now_s;
            report_seen   = 1'b1;
            if (!tracking_on)
            begin
                tracking_on = 1'b1;
                started     = 1'b1;
            end
            // a grid one wide or less points that axis at its centre
            tgt_pan  = (it.gw > 1) ? (int'(it.col) * PAN_TOP) / (int'(it.gw) - 1)
                                   : PAN_CENTRE;
            tgt_tilt = (it.gh > 1) ? (int'(it.row) * TILT_TOP) / (int'(it.gh) - 1)
                                   : TILT_CENTRE;
            // out-of-range step limit falls back to the default
            step_lim = (cfg_max_step < 1 || cfg_max_step > 10) ? 3 : cfg_max_step;
            dpan     = clip_step(tgt_pan - head_pan, cfg_dead_zone, step_lim);
            dtilt    = clip_step(tgt_tilt - head_tilt, cfg_dead_zone, step_lim);
        end

        dpan  = bound_step(head_pan, dpan, PAN_TOP);
        dtilt = bound_step(head_tilt, dtilt, TILT_TOP);
        if (dpan != 0 || dtilt != 0)
        begin
            head_pan  += dpan;
            head_tilt += dtilt;
        end
        else
            home = 1'b0;

        res.move_valid       = (dpan != 0 || dtilt != 0);
        res.pan_direction    = (dpan < 0);
        res.pan_distance     = ptmf_pkg::PAN_OUT_W'((dpan < 0) ? -dpan : dpan);
        res.tilt_direction   = (dtilt > 0);
        res.tilt_distance    = ptmf_pkg::TILT_OUT_W'((dtilt < 0) ? -dtilt : dtilt);
        res.pan_now          = ptmf_pkg::PAN_OUT_W'(head_pan);
        res.tilt_now         = ptmf_pkg::TILT_OUT_W'(head_tilt);
        res.active_flag      = tracking_on;
        res.tracking_started = started;
        res.went_home        = home;
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // table builders
    // ------------------------------------------------------------------------
    function automatic move_cmd_t typed_move(input bit mv, input bit pdir, input int pdist,
                                             input bit tdir, input int tdist, input int pan,
                                             input int tilt, input bit act, input bit st,
                                             input bit home);
        move_cmd_t m;
        m = '{mv, pdir, ptmf_pkg::PAN_OUT_W'(pdist), tdir, ptmf_pkg::TILT_OUT_W'(tdist),
              ptmf_pkg::PAN_OUT_W'(pan), ptmf_pkg::TILT_OUT_W'(tilt), act, st, home};
        return m;
    endfunction

    function automatic stim_row_t cfg_row(input ptmf_pkg::ptmf_reg_t which,
                                          input int unsigned v);
        stim_row_t r;
        r.is_cfg  = 1'b1;
        r.cfg_reg = which;
        r.cfg_val = v;
        r.item    = '{default: '0};
        r.typed   = 1'b0;
        r.want    = '0;
        return r;
    endfunction

    function automatic stim_row_t item_row(input logic op, input int col, input int row,
                                           input int gw, input int gh,
                                           input logic [31:0] now_s,
                                           input bit typed = 1'b0,
                                           input move_cmd_t want = '0);
        stim_row_t r;
        r.is_cfg  = 1'b0;
        r.cfg_reg = ptmf_pkg::REG_DEAD_ZONE;
        r.cfg_val = 0;
        r.item    = '{op, ptmf_pkg::COORD_W'(col), ptmf_pkg::COORD_W'(row),
                      ptmf_pkg::COORD_W'(gw), ptmf_pkg::COORD_W'(gh), now_s};
        r.typed   = typed;
        r.want    = want;
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // random beat: mostly centroids inside a sensible grid with time moving
    // forward slowly, plus grids one wide, raw noise and clock jumps
    // ------------------------------------------------------------------------
    function automatic motion_item_t random_item();
        motion_item_t it;
        int           pick;
        pick = $urandom_range(99);
        if (pick < 4)
            clock_s = $urandom;
        else if (pick < 20)
            clock_s += $urandom_range(0, 300);
        else
            clock_s += $urandom_range(0, 4);
        it.now_s = clock_s;
        it.op    = ($urandom_range(99) < 30) ? ptmf_pkg::OP_POLL : ptmf_pkg::OP_REPORT;

        pick = $urandom_range(99);
        if (pick < 10 || it.op == ptmf_pkg::OP_POLL)
        begin
            // raw noise, all bits free
            it.col = ptmf_pkg::COORD_W'($urandom);
            it.row = ptmf_pkg::COORD_W'($urandom);
            it.gw  = ptmf_pkg::COORD_W'($urandom);
            it.gh  = ptmf_pkg::COORD_W'($urandom);
        end
        else
        begin
            it.gw = ($urandom_range(19) == 0) ? ptmf_pkg::COORD_W'($urandom_range(0, 1))
                  : ($urandom_range(9) == 0) ? ptmf_pkg::COORD_W'($urandom_range(2, 255))
                  : ptmf_pkg::COORD_W'($urandom_range(2, 40));
            it.gh = ($urandom_range(19) == 0) ? ptmf_pkg::COORD_W'($urandom_range(0, 1))
                  : ($urandom_range(9) == 0) ? ptmf_pkg::COORD_W'($urandom_range(2, 255))
                  : ptmf_pkg::COORD_W'($urandom_range(2, 30));
            it.col = (it.gw > 1) ? ptmf_pkg::COORD_W'($urandom_range(0, it.gw - 1))
                                 : ptmf_pkg::COORD_W'($urandom_range(0, 255));
            it.row = (it.gh > 1) ? ptmf_pkg::COORD_W'($urandom_range(0, it.gh - 1))
                                 : ptmf_pkg::COORD_W'($urandom_range(0, 255));
        end
        return it;
    endfunction

    // ------------------------------------------------------------------------
    // apb access: setup cycle, access cycle, done when pready is seen
    // ------------------------------------------------------------------------
    task automatic apb_access(input bit wr, input ptmf_pkg::ptmf_reg_t which,
                              input int unsigned wdata,
                              output logic [ptmf_pkg::APB_DATA_W-1:0] rdata);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {which, 2'b00};
        pwdata  <= wdata;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        rdata = prdata;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // write a register, mirror it in the model and read it back
    task automatic write_reg(input ptmf_pkg::ptmf_reg_t which, input int unsigned v);
        logic [ptmf_pkg::APB_DATA_W-1:0] rd;
        int unsigned                     kept;
        case (which)
            ptmf_pkg::REG_DEAD_ZONE:
            begin
                kept          = v & 31;
                cfg_dead_zone = kept;
            end
            ptmf_pkg::REG_MAX_STEP:
            begin
                kept         = v & 15;
                cfg_max_step = kept;
            end
            ptmf_pkg::REG_HOME_ENABLE:
            begin
                kept        = v & 1;
                cfg_home_en = kept[0];
            end
            default:
            begin
                kept         = v & 255;
                cfg_home_tmo = kept;
            end
        endcase
        apb_access(1'b1, which, v, rd);
        apb_access(1'b0, which, 0, rd);
        if (rd !== ptmf_pkg::APB_DATA_W'(kept))
            flag_mismatch($sformatf("readback of %s", which.name()), rd, kept);
        n_cfg_writes++;
    endtask

    // only touch registers once every result is back and no beat is offered
    task automatic wait_idle();
        @(negedge clk);
        motion_bus.valid <= 1'b0;
        while (pending_moves.size() != 0)
            @(posedge clk);
    endtask

    // ------------------------------------------------------------------------
    // input side: offer one beat, predict at the accepting edge
    // ------------------------------------------------------------------------
    task automatic send_item(input motion_item_t it, input bit typed = 1'b0,
                             input move_cmd_t want = '0);
        move_cmd_t predicted;
        @(negedge clk);
        while ($urandom_range(99) < src_idle_pct)
        begin
            motion_bus.valid <= 1'b0;
            @(negedge clk);
        end
        motion_bus.valid         <= 1'b1;
        motion_bus.op            <= it.op;
        motion_bus.motion_column <= it.col;
        motion_bus.motion_row    <= it.row;
        motion_bus.grid_width    <= it.gw;
        motion_bus.grid_height   <= it.gh;
        motion_bus.now_seconds   <= it.now_s;
        @(posedge clk);
        while (!motion_bus.ready)
            @(posedge clk);
        predicted = predict_move(it);
        // a hand-written row stands in for the prediction; the model still advances
        pending_moves.push_back(typed ? want : predicted);
        if (it.op == ptmf_pkg::OP_POLL)
            n_polls++;
        else
            n_reports++;
    endtask

    // ------------------------------------------------------------------------
    // output side: random back-pressure, driven at the falling edge
    // ------------------------------------------------------------------------
    initial
    begin
        command_bus.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            command_bus.ready <= ($urandom_range(99) >= snk_idle_pct);
        end
    end

    // compare each accepted result beat with the oldest prediction
    always @(posedge clk)
    begin : result_check
        move_cmd_t got;
        move_cmd_t want;
        if (rst_n && command_bus.valid === 1'b1 && command_bus.ready === 1'b1)
        begin
            got = '{command_bus.move_valid, command_bus.pan_direction,
                    command_bus.pan_distance, command_bus.tilt_direction,
                    command_bus.tilt_distance, command_bus.pan_now, command_bus.tilt_now,
                    command_bus.active_flag, command_bus.tracking_started,
                    command_bus.went_home};
            if (pending_moves.size() == 0)
                flag_mismatch("result beat with nothing pending", 1, 0);
            else
            begin
                want = pending_moves.pop_front();
                n_checked++;
                if (got.move_valid !== want.move_valid)
                    flag_mismatch("move_valid", got.move_valid, want.move_valid);
                if (got.pan_direction !== want.pan_direction)
                    flag_mismatch("pan_direction", got.pan_direction, want.pan_direction);
                if (got.pan_distance !== want.pan_distance)
                    flag_mismatch("pan_distance", got.pan_distance, want.pan_distance);
                if (got.tilt_direction !== want.tilt_direction)
                    flag_mismatch("tilt_direction", got.tilt_direction, want.tilt_direction);
                if (got.tilt_distance !== want.tilt_distance)
                    flag_mismatch("tilt_distance", got.tilt_distance, want.tilt_distance);
                if (got.pan_now !== want.pan_now)
                    flag_mismatch("pan_now", got.pan_now, want.pan_now);
                if (got.tilt_now !== want.tilt_now)
                    flag_mismatch("tilt_now", got.tilt_now, want.tilt_now);
                if (got.active_flag !== want.active_flag)
                    flag_mismatch("active_flag", got.active_flag, want.active_flag);
                if (got.tracking_started !== want.tracking_started)
                    flag_mismatch("tracking_started", got.tracking_started,
                                  want.tracking_started);
                if (got.went_home !== want.went_home)
                    flag_mismatch("went_home", got.went_home, want.went_home);
                if (want.move_valid)
                    n_moves++;
                if (want.went_home)
                    n_homes++;
                if (want.tracking_started)
                    n_starts++;
            end
        end
    end

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        // every input known from time zero
        rst_n                    = 1'b0;
        psel                     = 1'b0;
        penable                  = 1'b0;
        pwrite                   = 1'b0;
        paddr                    = '0;
        pwdata                   = '0;
        motion_bus.valid         = 1'b0;
        motion_bus.op            = ptmf_pkg::OP_REPORT;
        motion_bus.motion_column = '0;
        motion_bus.motion_row    = '0;
        motion_bus.grid_width    = '0;
        motion_bus.grid_height   = '0;
        motion_bus.now_seconds   = '0;

        // model state and settings as after reset
        head_pan      = PAN_CENTRE;
        head_tilt     = TILT_CENTRE;
        last_report_s = '0;
        report_seen   = 1'b0;
        tracking_on   = 1'b1;
        cfg_dead_zone = 2;
        cfg_max_step  = 3;
        cfg_home_en   = 1'b0;
        cfg_home_tmo  = 10;
        clock_s       = '0;

        mismatch_count = 0;
        n_reports      = 0;
        n_polls        = 0;
        n_checked      = 0;
        n_moves        = 0;
        n_homes        = 0;
        n_starts       = 0;
        n_cfg_writes   = 0;

        // first phase: sender idles lightly, receiver heavily
        src_idle_pct = 20;
        snk_idle_pct = 63;

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        directed_rows = {
            // poll straight after reset: flag drops, nothing moves
            item_row(ptmf_pkg::OP_POLL, 0, 0, 0, 0, 32'd0, 1'b1,
                     typed_move(0, 0, 0, 0, 0, 15, 7, 0, 0, 0)),
            // empty grid points at centre, tracking restarts
            item_row(ptmf_pkg::OP_REPORT, 0, 0, 0, 0, 32'd5, 1'b1,
                     typed_move(0, 0, 0, 0, 0, 15, 7, 1, 1, 0)),
            // centroid far outside a two-wide grid, clipped to the default step
            item_row(ptmf_pkg::OP_REPORT, 255, 255, 2, 2, 32'd6, 1'b1,
                     typed_move(1, 0, 3, 1, 3, 18, 10, 1, 0, 0)),
            cfg_row(ptmf_pkg::REG_DEAD_ZONE, 0),
            cfg_row(ptmf_pkg::REG_MAX_STEP, 10),
            // tilt runs into its upper bound
            item_row(ptmf_pkg::OP_REPORT, 255, 255, 2, 2, 32'd7),
            // grid one wide on both axes
            item_row(ptmf_pkg::OP_REPORT, 255, 255, 1, 1, 32'd8),
            item_row(ptmf_pkg::OP_REPORT, 255, 255, 255, 255, 32'd9),
            item_row(ptmf_pkg::OP_REPORT, 255, 255, 255, 255, 32'd10),
            // both axes at their bounds, target beyond: no move
            item_row(ptmf_pkg::OP_REPORT, 255, 255, 2, 2, 32'd11),
            // step limit of zero and above ten fall back to three
            cfg_row(ptmf_pkg::REG_MAX_STEP, 0),
            item_row(ptmf_pkg::OP_REPORT, 0, 0, 255, 255, 32'd12),
            cfg_row(ptmf_pkg::REG_MAX_STEP, 15),
            item_row(ptmf_pkg::OP_REPORT, 0, 0, 200, 100, 32'd13),
            // widest dead zone swallows the error
            cfg_row(ptmf_pkg::REG_DEAD_ZONE, 31),
            item_row(ptmf_pkg::OP_REPORT, 0, 0, 255, 255, 32'd14),
            cfg_row(ptmf_pkg::REG_DEAD_ZONE, 2),
            cfg_row(ptmf_pkg::REG_HOME_TMO, 0),
            cfg_row(ptmf_pkg::REG_HOME_ENABLE, 1),
            // zero timeout: immediate return to centre, then none until a report
            item_row(ptmf_pkg::OP_POLL, 0, 0, 0, 0, 32'd14),
            item_row(ptmf_pkg::OP_POLL, 255, 255, 255, 255, 32'd100),
            // longest timeout measured across the wrap of the seconds counter
            cfg_row(ptmf_pkg::REG_HOME_TMO, 255),
            item_row(ptmf_pkg::OP_REPORT, 0, 0, 255, 255, 32'hFFFF_FF80),
            item_row(ptmf_pkg::OP_POLL, 0, 0, 0, 0, 32'h0000_007E),
            item_row(ptmf_pkg::OP_POLL, 0, 0, 0, 0, 32'h0000_007F)
        };

        foreach (directed_rows[i])
        begin
            if (directed_rows[i].is_cfg)
            begin
                wait_idle();
                write_reg(directed_rows[i].cfg_reg, directed_rows[i].cfg_val);
            end
            else
                send_item(directed_rows[i].item, directed_rows[i].typed,
                          directed_rows[i].want);
        end
        clock_s = 32'h0000_007F;

        // random segments, each under its own settings
        for (int seg = 0; seg < RANDOM_SEGS; seg++)
        begin
            wait_idle();
            case (seg / 2)
                0:
                begin
                    src_idle_pct = 20;
                    snk_idle_pct = 63;
                end
                1:
                begin
                    src_idle_pct = 63;
                    snk_idle_pct = 20;
                end
                default:
                begin
                    src_idle_pct = 0;
                    snk_idle_pct = 0;
                end
            endcase
            case (seg)
                0:
                begin
                    write_reg(ptmf_pkg::REG_DEAD_ZONE, 0);
                    write_reg(ptmf_pkg::REG_MAX_STEP, 10);
                    write_reg(ptmf_pkg::REG_HOME_ENABLE, 1);
                    write_reg(ptmf_pkg::REG_HOME_TMO, 0);
                end
                1:
                begin
                    write_reg(ptmf_pkg::REG_DEAD_ZONE, 5);
                    write_reg(ptmf_pkg::REG_MAX_STEP, 1);
                    write_reg(ptmf_pkg::REG_HOME_ENABLE, 1);
                    write_reg(ptmf_pkg::REG_HOME_TMO, 255);
                end
                2:
                begin
                    // reset settings again
                    write_reg(ptmf_pkg::REG_DEAD_ZONE, 2);
                    write_reg(ptmf_pkg::REG_MAX_STEP, 3);
                    write_reg(ptmf_pkg::REG_HOME_ENABLE, 1);
                    write_reg(ptmf_pkg::REG_HOME_TMO, 10);
                end
                3:
                begin
                    write_reg(ptmf_pkg::REG_DEAD_ZONE, $urandom_range(0, 6));
                    write_reg(ptmf_pkg::REG_MAX_STEP, $urandom_range(0, 15));
                    write_reg(ptmf_pkg::REG_HOME_ENABLE, 1);
                    write_reg(ptmf_pkg::REG_HOME_TMO, $urandom_range(0, 30));
                end
                4:
                begin
                    write_reg(ptmf_pkg::REG_DEAD_ZONE, 1);
                    write_reg(ptmf_pkg::REG_MAX_STEP, 15);
                    write_reg(ptmf_pkg::REG_HOME_ENABLE, 0);
                    write_reg(ptmf_pkg::REG_HOME_TMO, 5);
                end
                default:
                begin
                    // upper bits set too, the block keeps only the field
                    write_reg(ptmf_pkg::REG_DEAD_ZONE, $urandom & 32'hFFFF_FFE7);
                    write_reg(ptmf_pkg::REG_MAX_STEP, $urandom_range(0, 15));
                    write_reg(ptmf_pkg::REG_HOME_ENABLE, $urandom);
                    write_reg(ptmf_pkg::REG_HOME_TMO, $urandom);
                end
            endcase
            repeat (SEG_BEATS)
                send_item(random_item());
        end

        // drain, then let the pipeline settle
        @(negedge clk);
        motion_bus.valid <= 1'b0;
        while (pending_moves.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);

        $display("run covered %0d reports and %0d polls over %0d register writes",
                 n_reports, n_polls, n_cfg_writes);
        $display("%0d results checked: %0d moves, %0d returns to centre, %0d restarts",
                 n_checked, n_moves, n_homes, n_starts);
        if (mismatch_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/core/ptmf_pkg.sv
rtl/core/ptmf_item_if.sv
rtl/core/ptmf_result_if.sv
rtl/core/ptmf_ctrl.sv
rtl/core/ptmf_dp.sv
rtl/core/pan_tilt_motion_follower_core.sv
verif/pan_tilt_motion_follower_core_tb.sv
